// ===== src/ryuv_pkg.sv =====
`timescale 1ns / 1ps

package ryuv_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 4'd1;

    localparam logic [CFG_DATA_W-1:0] DIM_RESET = 13'd256;

    // chroma kind codes
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_U    = 2'd1;
    localparam logic [1:0] KIND_V    = 2'd2;

    // bt.601 coefficients, magnitudes; signs are applied in the sums
    localparam logic [15:0] C_Y_R = 16'd66;
    localparam logic [15:0] C_Y_G = 16'd129;
    localparam logic [15:0] C_Y_B = 16'd25;
    localparam logic [15:0] C_U_R = 16'd38;
    localparam logic [15:0] C_U_G = 16'd74;
    localparam logic [15:0] C_U_B = 16'd112;
    localparam logic [15:0] C_V_R = 16'd112;
    localparam logic [15:0] C_V_G = 16'd94;
    localparam logic [15:0] C_V_B = 16'd18;
    localparam logic [15:0] C_ROUND = 16'd128;

    localparam logic [7:0] OFS_LUMA   = 8'd16;
    localparam logic [7:0] OFS_CHROMA = 8'd128;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [7:0] luma;
        logic [1:0] chroma_kind;
        logic [7:0] chroma;
        logic       end_of_frame;
    } t_result;

    // classified pixel handed from front to back
    typedef struct packed {
        t_pixel     pixel;
        logic [1:0] kind;
        logic       eof;
    } t_cmd;

endpackage

// ===== src/rgb24_to_yuv420_converter.sv =====
`timescale 1ns / 1ps

// channel   direction  handshake                    payload
// pixel     in         push / full                  i_pixel  (red, green, blue)
// result    out        empty / pop                  o_result (luma, chroma_kind, chroma, eof)
// config    in         i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// one pixel per clock while full stays low; a pixel reaches the result ports through
// the pixel queue, the product register and the result queue
// reset is synchronous, active low; counters go to zero, dimensions to 256
// a stalled consumer fills the result queue, then the product stage, then the
// pixel queue, after which full rises; config writes are always taken

module rgb24_to_yuv420_converter #(
    parameter int MAX_DIMENSION = 4096,
    parameter int CMD_DEPTH     = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ryuv_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ryuv_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            push,
    input  ryuv_pkg::t_pixel                i_pixel,
    output logic                            full,
    output logic                            empty,
    input  logic                            pop,
    output ryuv_pkg::t_result               o_result
);

    localparam int CMD_W = $bits(ryuv_pkg::t_cmd);

    logic             cmd_push, cmd_full, cmd_pop, cmd_empty;
    ryuv_pkg::t_cmd   cmd_in;
    logic [CMD_W-1:0] cmd_in_bits, cmd_out_bits;

    // front: configuration, counters, classification
    ryuv_front #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_push      (push),
        .i_pixel     (i_pixel),
        .o_full      (full),
        .o_cmd_push  (cmd_push),
        .o_cmd       (cmd_in),
        .i_cmd_full  (cmd_full)
    );

    assign cmd_in_bits = cmd_in;

    // queue between front and back
    ryuv_fifo #(
        .W     (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in_bits),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_out_bits),
        .o_empty (cmd_empty)
    );

    // back: color arithmetic and result queue
    ryuv_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (ryuv_pkg::t_cmd'(cmd_out_bits)),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .o_result    (o_result),
        .o_empty     (empty),
        .i_pop       (pop)
    );

endmodule

// ===== src/ryuv_fifo.sv =====
`timescale 1ns / 1ps

module ryuv_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          wr_en, rd_en;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // pointer and count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (wr_en && !rd_en) begin
            n_count = r_count + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== src/ryuv_front.sv =====
`timescale 1ns / 1ps

module ryuv_front #(
    parameter int MAX_DIMENSION = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ryuv_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ryuv_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_push,
    input  ryuv_pkg::t_pixel                  i_pixel,
    output logic                              o_full,
    output logic                              o_cmd_push,
    output ryuv_pkg::t_cmd                    o_cmd,
    input  logic                              i_cmd_full
);

    localparam int CNT_W = $clog2(MAX_DIMENSION);
    localparam int DIM_W = ($clog2(MAX_DIMENSION + 1) > ryuv_pkg::CFG_DATA_W)
                         ? $clog2(MAX_DIMENSION + 1) : ryuv_pkg::CFG_DATA_W;
    localparam int CMP_W = DIM_W + 1;

    logic [ryuv_pkg::CFG_DATA_W-1:0] r_frame_width;
    logic [ryuv_pkg::CFG_DATA_W-1:0] r_frame_height;
    logic [CNT_W-1:0]                r_col, n_col;
    logic [CNT_W-1:0]                r_row, n_row;
    logic [CMP_W-1:0]                w_eff, h_eff;
    logic                            last_col, last_row;
    logic                            accept;

    assign o_cfg_ready = 1'b1;
    assign o_full      = i_cmd_full;
    assign accept      = i_push && !i_cmd_full;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= ryuv_pkg::DIM_RESET;
            r_frame_height <= ryuv_pkg::DIM_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == ryuv_pkg::CFG_FRAME_WIDTH) begin
                r_frame_width <= i_cfg_data;
            end
            if (i_cfg_index == ryuv_pkg::CFG_FRAME_HEIGHT) begin
                r_frame_height <= i_cfg_data;
            end
        end
    end

    // effective dimensions: zero acts as one, too large acts as the maximum
    always_comb begin
        w_eff = CMP_W'(r_frame_width);
        if (r_frame_width == '0) begin
            w_eff = CMP_W'(1);
        end else if (w_eff > CMP_W'(MAX_DIMENSION)) begin
            w_eff = CMP_W'(MAX_DIMENSION);
        end
        h_eff = CMP_W'(r_frame_height);
        if (r_frame_height == '0) begin
            h_eff = CMP_W'(1);
        end else if (h_eff > CMP_W'(MAX_DIMENSION)) begin
            h_eff = CMP_W'(MAX_DIMENSION);
        end
    end

    // position in frame
    assign last_col = (CMP_W'(r_col) + 1'b1) >= w_eff;
    assign last_row = (CMP_W'(r_row) + 1'b1) >= h_eff;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (last_col) begin
                n_col = '0;
                n_row = last_row ? '0 : r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // classify the item for the back end
    always_comb begin
        o_cmd.pixel = i_pixel;
        o_cmd.eof   = last_col && last_row;
        if (r_col[0]) begin
            o_cmd.kind = ryuv_pkg::KIND_NONE;
        end else if (r_row[0]) begin
            o_cmd.kind = ryuv_pkg::KIND_V;
        end else begin
            o_cmd.kind = ryuv_pkg::KIND_U;
        end
    end

    assign o_cmd_push = accept;

endmodule

// ===== src/ryuv_back.sv =====
`timescale 1ns / 1ps

module ryuv_back #(
    parameter int OUT_DEPTH = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ryuv_pkg::t_cmd     i_cmd,
    input  logic               i_cmd_empty,
    output logic               o_cmd_pop,
    output ryuv_pkg::t_result  o_result,
    output logic               o_empty,
    input  logic               i_pop
);

    localparam int RES_W = $bits(ryuv_pkg::t_result);

    logic              r_s1_valid;
    logic [7:0]        r_s1_y, r_s1_u, r_s1_v;
    logic [1:0]        r_s1_kind;
    logic              r_s1_eof;
    logic              out_full;
    logic              s1_advance;
    logic [15:0]       red16, green16, blue16;
    logic [15:0]       sum_y, sum_u, sum_v;
    ryuv_pkg::t_result res;
    logic [RES_W-1:0]  res_bits;
    logic [RES_W-1:0]  out_bits;

    assign s1_advance = r_s1_valid && !out_full;
    assign o_cmd_pop  = !i_cmd_empty && (!r_s1_valid || !out_full);

    // weighted sums, modulo 2^16; bits 15:8 are the floor shift modulo 256
    assign red16   = 16'(i_cmd.pixel.red);
    assign green16 = 16'(i_cmd.pixel.green);
    assign blue16  = 16'(i_cmd.pixel.blue);

    assign sum_y = ryuv_pkg::C_Y_R * red16 + ryuv_pkg::C_Y_G * green16
                 + ryuv_pkg::C_Y_B * blue16 + ryuv_pkg::C_ROUND;
    assign sum_u = ryuv_pkg::C_U_B * blue16 - ryuv_pkg::C_U_R * red16
                 - ryuv_pkg::C_U_G * green16 + ryuv_pkg::C_ROUND;
    assign sum_v = ryuv_pkg::C_V_R * red16 - ryuv_pkg::C_V_G * green16
                 - ryuv_pkg::C_V_B * blue16 + ryuv_pkg::C_ROUND;

    // product stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_cmd_pop) begin
            r_s1_valid <= 1'b1;
        end else if (s1_advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_s1_y    <= sum_y[15:8];
            r_s1_u    <= sum_u[15:8];
            r_s1_v    <= sum_v[15:8];
            r_s1_kind <= i_cmd.kind;
            r_s1_eof  <= i_cmd.eof;
        end
    end

    // offsets and chroma select
    always_comb begin
        res.luma         = r_s1_y + ryuv_pkg::OFS_LUMA;
        res.chroma_kind  = r_s1_kind;
        res.end_of_frame = r_s1_eof;
        unique case (r_s1_kind)
            ryuv_pkg::KIND_U: res.chroma = r_s1_u + ryuv_pkg::OFS_CHROMA;
            ryuv_pkg::KIND_V: res.chroma = r_s1_v + ryuv_pkg::OFS_CHROMA;
            default:          res.chroma = 8'd0;
        endcase
    end

    assign res_bits = res;

    // result queue towards the consumer
    ryuv_fifo #(
        .W     (RES_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s1_advance),
        .i_data  (res_bits),
        .o_full  (out_full),
        .i_pop   (i_pop),
        .o_data  (out_bits),
        .o_empty (o_empty)
    );

    assign o_result = ryuv_pkg::t_result'(out_bits);

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int MAX_DIM      = 4096;
    localparam int RANDOM_ITEMS = 1000;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int SETTLE       = 8;
    localparam int REPORT_LIMIT = 10;
    localparam int IDX_W        = ryuv_pkg::CFG_IDX_W;
    localparam int DATA_W       = ryuv_pkg::CFG_DATA_W;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [IDX_W-1:0]  i_cfg_index;
    logic [DATA_W-1:0] i_cfg_data;
    logic              push;
    ryuv_pkg::t_pixel  i_pixel;
    logic              full;
    logic              empty;
    logic              pop;
    ryuv_pkg::t_result o_result;

    rgb24_to_yuv420_converter i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .push       (push),
        .i_pixel    (i_pixel),
        .full       (full),
        .empty      (empty),
        .pop        (pop),
        .o_result   (o_result)
    );

    // converter state as seen by the predictor
    logic [DATA_W-1:0] frame_w_reg;
    logic [DATA_W-1:0] frame_h_reg;
    logic [12:0]       col_pos;
    logic [12:0]       row_pos;

    ryuv_pkg::t_result pending_yuv[$];
    int                fail_count;
    int                pixels_sent;
    bit                src_gaps_on;
    bit                sink_gaps_on;
    int                sink_hold;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("rgb24_to_yuv420_converter: mismatch");
        $finish;
    end

    function automatic logic [DATA_W-1:0] clamp_dim(input logic [DATA_W-1:0] v);
        if (v == 0)
            return DATA_W'(1);
        if (int'(v) > MAX_DIM)
            return DATA_W'(MAX_DIM);
        return v;
    endfunction

    // floor shift by 8 plus offset, wrapped to a byte
    function automatic logic [7:0] scale_offset(input int sum, input logic [7:0] ofs);
        return 8'((sum >>> 8) + int'(ofs));
    endfunction

    // expected yuv result for one pixel, advances the frame position
    function automatic ryuv_pkg::t_result predict_yuv(input ryuv_pkg::t_pixel px);
        ryuv_pkg::t_result res;
        int r, g, b;
        int w, h;
        logic last_col, last_row;
        r = int'(px.red);
        g = int'(px.green);
        b = int'(px.blue);
        w = int'(clamp_dim(frame_w_reg));
        h = int'(clamp_dim(frame_h_reg));
        last_col = int'(col_pos) + 1 >= w;
        last_row = int'(row_pos) + 1 >= h;

        res.luma = scale_offset(int'(ryuv_pkg::C_Y_R) * r + int'(ryuv_pkg::C_Y_G) * g
                                + int'(ryuv_pkg::C_Y_B) * b + int'(ryuv_pkg::C_ROUND),
                                ryuv_pkg::OFS_LUMA);
        res.chroma_kind = ryuv_pkg::KIND_NONE;
        res.chroma      = 8'd0;
        if (!col_pos[0] && !row_pos[0]) begin
            res.chroma_kind = ryuv_pkg::KIND_U;
            res.chroma = scale_offset(-int'(ryuv_pkg::C_U_R) * r - int'(ryuv_pkg::C_U_G) * g
                                      + int'(ryuv_pkg::C_U_B) * b
                                      + int'(ryuv_pkg::C_ROUND), ryuv_pkg::OFS_CHROMA);
        end else if (!col_pos[0]) begin
            res.chroma_kind = ryuv_pkg::KIND_V;
            res.chroma = scale_offset(int'(ryuv_pkg::C_V_R) * r - int'(ryuv_pkg::C_V_G) * g
                                      - int'(ryuv_pkg::C_V_B) * b
                                      + int'(ryuv_pkg::C_ROUND), ryuv_pkg::OFS_CHROMA);
        end
        res.end_of_frame = last_col && last_row;

        if (last_col) begin
            col_pos = '0;
            row_pos = last_row ? 13'd0 : row_pos + 13'd1;
        end else begin
            col_pos = col_pos + 13'd1;
        end
        return res;
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("%0t: %s", $realtime, msg);
    endtask

    // result checker
    always @(posedge i_clk) begin
        ryuv_pkg::t_result want;
        if (i_rst_n && pop && !empty) begin
            if (pending_yuv.size() == 0) begin
                note_failure($sformatf(
                             "result with nothing pending: y=%0d kind=%0d c=%0d eof=%0d",
                             o_result.luma, o_result.chroma_kind, o_result.chroma,
                             o_result.end_of_frame));
            end else begin
                want = pending_yuv.pop_front();
                if (o_result.luma != want.luma ||
                    o_result.chroma_kind != want.chroma_kind ||
                    o_result.chroma != want.chroma ||
                    o_result.end_of_frame != want.end_of_frame)
                    note_failure($sformatf({"yuv differs: exp y=%0d kind=%0d c=%0d eof=%0d",
                                 " got y=%0d kind=%0d c=%0d eof=%0d"},
                                 want.luma, want.chroma_kind, want.chroma,
                                 want.end_of_frame, o_result.luma, o_result.chroma_kind,
                                 o_result.chroma, o_result.end_of_frame));
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result consumer: random pops, long hold when requested
    initial begin
        int gap_left;
        gap_left = 0;
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_hold > 0) begin
                pop = 1'b0;
                sink_hold--;
            end else if (gap_left > 0) begin
                pop = 1'b0;
                gap_left--;
            end else if (sink_gaps_on && $urandom_range(3) == 0) begin
                pop = 1'b0;
                gap_left = $urandom_range(99) < 90 ? $urandom_range(0, 2)
                                                   : $urandom_range(9, 39);
            end else begin
                pop = 1'b1;
            end
        end
    end

    // offer one pixel, return once it is taken
    task automatic send_pixel(input ryuv_pkg::t_pixel px);
        int gap;
        gap = src_gaps_on ? pick_gap() : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            push = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push    = 1'b1;
        i_pixel = px;
        forever begin
            @(posedge i_clk);
            if (!full)
                break;
        end
        pending_yuv.push_back(predict_yuv(px));
        pixels_sent++;
    endtask

    // stop sending and wait for every pending result
    task automatic drain_results();
        int waited;
        waited = 0;
        @(negedge i_clk);
        push = 1'b0;
        while (pending_yuv.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_yuv.size() != 0) begin
            fail_count += pending_yuv.size();
            $display("%0t: %0d results never arrived", $realtime, pending_yuv.size());
            pending_yuv.delete();
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready)
                break;
        end
        if (idx == ryuv_pkg::CFG_FRAME_WIDTH)
            frame_w_reg = val;
        else if (idx == ryuv_pkg::CFG_FRAME_HEIGHT)
            frame_h_reg = val;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_frame(input logic [DATA_W-1:0] w, input logic [DATA_W-1:0] h);
        write_reg(ryuv_pkg::CFG_FRAME_WIDTH, w);
        write_reg(ryuv_pkg::CFG_FRAME_HEIGHT, h);
    endtask

    function automatic ryuv_pkg::t_pixel mk_pixel(input logic [7:0] r, input logic [7:0] g,
                                                  input logic [7:0] b);
        ryuv_pkg::t_pixel px;
        px.red   = r;
        px.green = g;
        px.blue  = b;
        return px;
    endfunction

    // components lean toward the rails now and then
    function automatic logic [7:0] rand_component();
        case ($urandom_range(7))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic ryuv_pkg::t_pixel rand_pixel();
        return mk_pixel(rand_component(), rand_component(), rand_component());
    endfunction

    // primaries and rails at the reset frame size
    task automatic test_color_extremes();
        src_gaps_on  = 1'b0;
        sink_gaps_on = 1'b0;
        send_pixel(mk_pixel(8'd0, 8'd0, 8'd0));
        send_pixel(mk_pixel(8'd255, 8'd255, 8'd255));
        send_pixel(mk_pixel(8'd255, 8'd0, 8'd0));
        send_pixel(mk_pixel(8'd0, 8'd255, 8'd0));
        send_pixel(mk_pixel(8'd0, 8'd0, 8'd255));
        send_pixel(mk_pixel(8'd255, 8'd255, 8'd0));
        send_pixel(mk_pixel(8'd0, 8'd255, 8'd255));
        send_pixel(mk_pixel(8'd255, 8'd0, 8'd255));
        drain_results();
    endtask

    // u, none, v and end of frame with eight pixels at a 2x2 frame size
    task automatic test_chroma_pattern();
        set_frame(13'd2, 13'd2);
        src_gaps_on  = 1'b1;
        sink_gaps_on = 1'b1;
        repeat (8) send_pixel(rand_pixel());
        drain_results();
    endtask

    // zero and oversize dimensions, writes to unused indexes
    task automatic test_dimension_clamp();
        set_frame(13'd0, 13'd0);
        repeat (3) send_pixel(rand_pixel());
        drain_results();
        set_frame(13'h1FFF, 13'h1FFF);
        repeat (2) send_pixel(rand_pixel());
        drain_results();
        set_frame(13'd3, 13'd1);
        for (int k = int'(ryuv_pkg::CFG_FRAME_HEIGHT) + 1; k < (1 << IDX_W); k++)
            write_reg(IDX_W'(k), (k % 2 == 0) ? 13'h1FFF : 13'd0);
        repeat (4) send_pixel(rand_pixel());
        drain_results();
    endtask

    // shrink the frame while the counters sit past the new bounds
    task automatic test_resize_mid_frame();
        set_frame(13'd16, 13'd8);
        repeat (11) send_pixel(rand_pixel());
        drain_results();
        write_reg(ryuv_pkg::CFG_FRAME_WIDTH, 13'd4);
        repeat (6) send_pixel(rand_pixel());
        drain_results();
        write_reg(ryuv_pkg::CFG_FRAME_HEIGHT, 13'd1);
        repeat (5) send_pixel(rand_pixel());
        drain_results();
    endtask

    function automatic logic [DATA_W-1:0] rand_dim();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return DATA_W'($urandom_range(1, 12));
        if (r < 90)
            return DATA_W'($urandom_range(13, 80));
        if (r < 95)
            return 13'd0;
        return DATA_W'($urandom_range(MAX_DIM, 8191));
    endfunction

    // whole frames of random pixels over random frame sizes
    task automatic test_random_frames();
        int target;
        int area;
        int count;
        logic [DATA_W-1:0] w, h;
        target = pixels_sent + RANDOM_ITEMS;
        while (pixels_sent < target) begin
            w = rand_dim();
            h = rand_dim();
            set_frame(w, h);
            area = int'(clamp_dim(w)) * int'(clamp_dim(h));
            count = area <= 120 ? area * $urandom_range(1, 3) : $urandom_range(20, 120);
            if ($urandom_range(4) == 0)
                count = count + $urandom_range(1, 5);
            src_gaps_on  = $urandom_range(3) != 0;
            sink_gaps_on = $urandom_range(3) != 0;
            repeat (count) send_pixel(rand_pixel());
            drain_results();
        end
    endtask

    // consumer holds off long enough for the input to stall
    task automatic test_backpressure();
        set_frame(13'd6, 13'd3);
        src_gaps_on  = 1'b0;
        sink_gaps_on = 1'b0;
        sink_hold    = 200;
        repeat (60) send_pixel(rand_pixel());
        drain_results();
        src_gaps_on  = 1'b1;
        sink_gaps_on = 1'b1;
        sink_hold    = 80;
        repeat (40) send_pixel(rand_pixel());
        drain_results();
    endtask

    // sequence
    initial begin
        i_rst_n      = 1'b0;
        push         = 1'b0;
        i_pixel      = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        fail_count   = 0;
        pixels_sent  = 0;
        src_gaps_on  = 1'b0;
        sink_gaps_on = 1'b0;
        sink_hold    = 0;
        frame_w_reg  = ryuv_pkg::DIM_RESET;
        frame_h_reg  = ryuv_pkg::DIM_RESET;
        col_pos      = '0;
        row_pos      = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_color_extremes();
        test_chroma_pattern();
        test_dimension_clamp();
        test_resize_mid_frame();
        test_random_frames();
        test_backpressure();

        drain_results();
        if (fail_count == 0)
            $display("rgb24_to_yuv420_converter: match");
        else
            $display("rgb24_to_yuv420_converter: mismatch");
        $finish;
    end

endmodule
